FILE: sv/bgo_pkg.sv
// ----------------------------------------------------------------------------
// bgo_pkg
// Shared widths, constants, types and the arctangent table for the block
// gradient orientation core.
// ----------------------------------------------------------------------------
package bgo_pkg;

	localparam int GRAD_W     = 14;
	localparam int TERM_W     = 2 * GRAD_W + 1;
	localparam int ACC_W      = 48;
	localparam int ANGLE_W    = 15;

	// CORDIC datapath
	localparam int CW         = 62;
	localparam int NORM_TOP   = 57;
	localparam int NORM_BIG   = 8;
	localparam int STEPS      = 22;
	localparam int STEP_W     = 5;
	localparam int Z_W        = 24;
	localparam int THETA_W    = 26;
	localparam int THETA_P_W  = 25;

	localparam logic [THETA_P_W-1:0] DEG180     = THETA_P_W'(11796480);
	localparam logic [THETA_P_W-1:0] DEG360     = THETA_P_W'(23592960);
	localparam logic [THETA_P_W-1:0] ROUND_HALF = THETA_P_W'(1024);
	localparam int                   H_SHIFT    = 11;
	localparam logic [ANGLE_W-1:0]   HALF_SPAN  = ANGLE_W'(11520);
	localparam logic [ANGLE_W-1:0]   ANGLE_BASE = ANGLE_W'(5760);

	typedef struct packed {
		logic signed [ACC_W-1:0] vx;
		logic signed [ACC_W-1:0] vy;
	} bgo_sums_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_ITER,
		ST_FIX,
		ST_DONE
	} bgo_state_t;

	// atan(2^-i) in units of 2^-16 degree
	function automatic logic signed [Z_W-1:0] atan_tab(input logic [STEP_W-1:0] i);
		logic [Z_W-1:0] v;
		case (i)
			5'd0:    v = Z_W'(2949120);
			5'd1:    v = Z_W'(1740967);
			5'd2:    v = Z_W'(919879);
			5'd3:    v = Z_W'(466945);
			5'd4:    v = Z_W'(234379);
			5'd5:    v = Z_W'(117304);
			5'd6:    v = Z_W'(58666);
			5'd7:    v = Z_W'(29335);
			5'd8:    v = Z_W'(14668);
			5'd9:    v = Z_W'(7334);
			5'd10:   v = Z_W'(3667);
			5'd11:   v = Z_W'(1833);
			5'd12:   v = Z_W'(917);
			5'd13:   v = Z_W'(458);
			5'd14:   v = Z_W'(229);
			5'd15:   v = Z_W'(115);
			5'd16:   v = Z_W'(57);
			5'd17:   v = Z_W'(29);
			5'd18:   v = Z_W'(14);
			5'd19:   v = Z_W'(7);
			5'd20:   v = Z_W'(4);
			5'd21:   v = Z_W'(2);
			default: v = '0;
		endcase
		return signed'(v);
	endfunction

endpackage

FILE: sv/bgo_if.sv
// ----------------------------------------------------------------------------
// bgo_if
// Valid/ready channels: gradient pixels in, block orientation results out.
// ----------------------------------------------------------------------------
interface bgo_pix_if;
	import bgo_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [GRAD_W-1:0] grad_x;
	logic signed [GRAD_W-1:0] grad_y;
	logic                     last_in_block;

	modport source (output valid, grad_x, grad_y, last_in_block, input ready);
	modport sink   (input valid, grad_x, grad_y, last_in_block, output ready);
endinterface

interface bgo_res_if;
	import bgo_pkg::*;

	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] angle;
	logic               flat_block;

	modport source (output valid, angle, flat_block, input ready);
	modport sink   (input valid, angle, flat_block, output ready);
endinterface

FILE: sv/bgo_front.sv
// ----------------------------------------------------------------------------
// bgo_front
// Per-pixel gradient products and the 48-bit vx/vy block accumulators.
// Pushes the finished sums of a block on its last pixel.
// ----------------------------------------------------------------------------
module bgo_front (
	input  logic              clk,
	input  logic              arst_n,
	bgo_pix_if.sink           pix,
	output logic              push_valid,
	output bgo_pkg::bgo_sums_t push_data,
	input  logic              push_ready
);
	import bgo_pkg::*;

	logic                       valid_s1;
	logic                       last_s1;
	logic signed [TERM_W-1:0]   vxt_s1;
	logic signed [TERM_W-1:0]   vyt_s1;
	logic signed [ACC_W-1:0]    vx_q;
	logic signed [ACC_W-1:0]    vy_q;

	logic signed [2*GRAD_W-1:0] prod_xy;
	logic signed [2*GRAD_W-1:0] sq_x;
	logic signed [2*GRAD_W-1:0] sq_y;
	logic signed [TERM_W-1:0]   vxt;
	logic signed [TERM_W-1:0]   vyt;
	logic signed [ACC_W-1:0]    vx_nxt;
	logic signed [ACC_W-1:0]    vy_nxt;
	logic                       consume;

	always_comb begin
		prod_xy = pix.grad_x * pix.grad_y;
		sq_x    = pix.grad_x * pix.grad_x;
		sq_y    = pix.grad_y * pix.grad_y;
		vxt     = {prod_xy, 1'b0};
		vyt     = {sq_x[2*GRAD_W-1], sq_x} - {sq_y[2*GRAD_W-1], sq_y};
	end

	assign vx_nxt = vx_q + {{(ACC_W-TERM_W){vxt_s1[TERM_W-1]}}, vxt_s1};
	assign vy_nxt = vy_q + {{(ACC_W-TERM_W){vyt_s1[TERM_W-1]}}, vyt_s1};

	// a last pixel waits in s1 until the queue has room
	assign consume    = valid_s1 && (!last_s1 || push_ready);
	assign pix.ready  = !valid_s1 || consume;
	assign push_valid = valid_s1 && last_s1;
	assign push_data  = '{vx: vx_nxt, vy: vy_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			vx_q     <= '0;
			vy_q     <= '0;
		end else begin
			if (pix.ready)
				valid_s1 <= pix.valid;
			if (consume) begin
				if (last_s1) begin
					vx_q <= '0;
					vy_q <= '0;
				end else begin
					vx_q <= vx_nxt;
					vy_q <= vy_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			last_s1 <= pix.last_in_block;
			vxt_s1  <= vxt;
			vyt_s1  <= vyt;
		end
	end

endmodule

FILE: sv/bgo_queue.sv
// ----------------------------------------------------------------------------
// bgo_queue
// Two-entry queue of block sums between the accumulator and the CORDIC.
// ----------------------------------------------------------------------------
module bgo_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  bgo_pkg::bgo_sums_t push_data,
	output logic               push_ready,
	output logic               pop_valid,
	output bgo_pkg::bgo_sums_t pop_data,
	input  logic               pop_ready
);
	import bgo_pkg::*;

	bgo_sums_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: sv/bgo_cordic.sv
// ----------------------------------------------------------------------------
// bgo_cordic
// Iterative CORDIC vectoring: normalize, 22 rotations, then half angle in
// 1/64 degree. One rotation per cycle; result held in an output register.
// ----------------------------------------------------------------------------
module bgo_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  bgo_pkg::bgo_sums_t q_data,
	output logic               q_ready,
	bgo_res_if.source          res
);
	import bgo_pkg::*;

	bgo_state_t state_q;
	bgo_state_t state_nxt;

	logic signed [CW-1:0]      x_q;
	logic signed [CW-1:0]      y_q;
	logic signed [Z_W-1:0]     z_q;
	logic [NORM_TOP:0]         mx_q;
	logic [STEP_W-1:0]         step_q;
	logic                      neg_q;
	logic                      flat_q;
	logic [THETA_P_W-1:0]      theta_q;
	logic                      res_valid_q;
	logic [ANGLE_W-1:0]        angle_q;
	logic                      res_flat_q;

	// control from the state decoder
	logic load_en;
	logic norm_en;
	logic iter_en;
	logic fix_en;
	logic res_load;

	logic signed [CW-1:0]      vx_ext;
	logic signed [CW-1:0]      vy_ext;
	logic signed [CW-1:0]      x0;
	logic signed [CW-1:0]      y0;
	logic signed [CW-1:0]      ay0;
	logic                      neg0;
	logic signed [CW-1:0]      dx;
	logic signed [CW-1:0]      dy;
	logic                      y_pos;
	logic                      norm_big;
	logic signed [THETA_W-1:0] theta_raw;
	logic signed [THETA_W-1:0] theta_fix;
	logic [THETA_P_W:0]        theta_rnd;
	logic [ANGLE_W-1:0]        h_raw;
	logic [ANGLE_W-1:0]        h_wrap;

	// -------- next state --------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid)
					state_nxt = (q_data.vx == '0) ? ST_FIX : ST_NORM;
			end
			ST_NORM: begin
				if (mx_q[NORM_TOP])
					state_nxt = ST_ITER;
			end
			ST_ITER: begin
				if (step_q == STEP_W'(STEPS - 1))
					state_nxt = ST_FIX;
			end
			ST_FIX:  state_nxt = ST_DONE;
			ST_DONE: begin
				if (!res_valid_q || res.ready)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// -------- outputs --------
	always_comb begin
		q_ready  = 1'b0;
		load_en  = 1'b0;
		norm_en  = 1'b0;
		iter_en  = 1'b0;
		fix_en   = 1'b0;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				load_en = q_valid;
			end
			ST_NORM: norm_en = !mx_q[NORM_TOP];
			ST_ITER: iter_en = 1'b1;
			ST_FIX:  fix_en  = 1'b1;
			ST_DONE: res_load = !res_valid_q || res.ready;
			default: ;
		endcase
	end

	// -------- datapath --------
	always_comb begin
		vx_ext = {{(CW-ACC_W){q_data.vx[ACC_W-1]}}, q_data.vx};
		vy_ext = {{(CW-ACC_W){q_data.vy[ACC_W-1]}}, q_data.vy};
		neg0   = q_data.vy[ACC_W-1];
		x0     = neg0 ? -vy_ext : vy_ext;
		y0     = neg0 ? -vx_ext : vx_ext;
		ay0    = y0[CW-1] ? -y0 : y0;

		norm_big = (mx_q[NORM_TOP -: NORM_BIG] == '0);

		dx    = y_q >>> step_q;
		dy    = x_q >>> step_q;
		y_pos = !y_q[CW-1] && (y_q != '0);

		theta_raw = (neg_q ? signed'({1'b0, DEG180}) : '0)
		            + {{(THETA_W-Z_W){z_q[Z_W-1]}}, z_q};
		theta_fix = theta_raw[THETA_W-1] ? theta_raw + signed'({1'b0, DEG360}) : theta_raw;

		theta_rnd = {1'b0, theta_q} + {1'b0, ROUND_HALF};
		h_raw     = ANGLE_W'(theta_rnd >> H_SHIFT);
		h_wrap    = (h_raw >= HALF_SPAN) ? h_raw - HALF_SPAN : h_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= '0;
			step_q <= '0;
			neg_q  <= neg0;
			flat_q <= (q_data.vx == '0);
			mx_q   <= (x0 > ay0) ? x0[NORM_TOP:0] : ay0[NORM_TOP:0];
		end
		if (norm_en) begin
			if (norm_big) begin
				x_q  <= x_q <<< NORM_BIG;
				y_q  <= y_q <<< NORM_BIG;
				mx_q <= mx_q << NORM_BIG;
			end else begin
				x_q  <= x_q <<< 1;
				y_q  <= y_q <<< 1;
				mx_q <= mx_q << 1;
			end
		end
		if (iter_en) begin
			step_q <= step_q + STEP_W'(1);
			if (y_pos) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_tab(step_q);
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_tab(step_q);
			end
		end
		if (fix_en)
			theta_q <= theta_fix[THETA_P_W-1:0];
		if (res_load) begin
			angle_q    <= flat_q ? '0 : ANGLE_BASE + h_wrap;
			res_flat_q <= flat_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.angle      = angle_q;
	assign res.flat_block = res_flat_q;

endmodule

FILE: sv/block_gradient_orientation.sv
// Flow: an accepted last pixel is registered in the front stage; its sums are
// pushed into the queue once it has room, then the CORDIC pops, normalizes,
// runs 22 rotations and finishes the angle; a flat block skips normalize/rotate.
// Throughput: one pixel per cycle unless a last pixel waits for queue room; the
// CORDIC takes one block at a time, and the two-entry sum queue buffers sums.
// Reset: arst_n clears the accumulators, queue, state machine and result valid.
// ----------------------------------------------------------------------------
// block_gradient_orientation
// Least-squares block orientation from per-pixel gradients.
// ----------------------------------------------------------------------------
module block_gradient_orientation (
	input  logic      clk,
	input  logic      arst_n,
	bgo_pix_if.sink   pix,
	bgo_res_if.source res
);
	import bgo_pkg::*;

	logic      push_valid;
	logic      push_ready;
	bgo_sums_t push_data;
	logic      pop_valid;
	logic      pop_ready;
	bgo_sums_t pop_data;

	bgo_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	bgo_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	bgo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_data  (pop_data),
		.q_ready (pop_ready),
		.res     (res)
	);

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams gradient pixels into block_gradient_orientation. Blocks are directed
// extremes, random blocks under three idling mixes, a long receiver hold-off
// and one long block of extreme pixels with large sums. Each result transaction
// is checked against an in-bench orientation predictor (exact sums plus a
// CORDIC atan2 on 64-bit integers).
// ----------------------------------------------------------------------------
module testbench;
	import bgo_pkg::GRAD_W;
	import bgo_pkg::ANGLE_W;
	import bgo_pkg::ACC_W;

	localparam int     GRAD_MAX       = 2 ** (GRAD_W - 1) - 1;
	localparam int     GRAD_MIN       = -(2 ** (GRAD_W - 1));
	localparam longint HALF_TURN      = 64'd11796480;
	localparam longint FULL_TURN      = 64'd23592960;
	localparam int     NORM_MSB       = 57;
	localparam int     ROT_STEPS      = 22;
	localparam longint ROUND_BIAS     = 64'd1024;
	localparam int     ROUND_SHIFT    = 11;
	localparam longint HALF_RANGE     = 64'd11520;
	localparam longint ANGLE_OFFSET   = 64'd5760;
	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     DRAIN_CYCLES   = 64;
	localparam int     LONG_PIXELS    = 64;

	typedef struct {
		logic [ANGLE_W-1:0] angle;
		logic               flat_block;
	} orient_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bgo_pix_if pix();
	bgo_res_if res();

	block_gradient_orientation dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	orient_t            expected_orient[$];
	logic [ACC_W-1:0]   sum_vx = '0;
	logic [ACC_W-1:0]   sum_vy = '0;
	int                 mismatches = 0;
	int                 quiet_cycles = 0;
	int                 src_idle_pct = 0;
	int                 snk_idle_pct = 0;
	int                 hold_off_cycles = 0;

	// atan(2^-i) in 2^-16 degree
	function automatic longint rotation_arc(input int i);
		case (i)
			0:  return 2949120;
			1:  return 1740967;
			2:  return 919879;
			3:  return 466945;
			4:  return 234379;
			5:  return 117304;
			6:  return 58666;
			7:  return 29335;
			8:  return 14668;
			9:  return 7334;
			10: return 3667;
			11: return 1833;
			12: return 917;
			13: return 458;
			14: return 229;
			15: return 115;
			16: return 57;
			17: return 29;
			18: return 14;
			19: return 7;
			20: return 4;
			21: return 2;
			default: return 0;
		endcase
	endfunction

	// 90 + atan2(vx, vy)/2 in 1/64 degree, atan2 by CORDIC vectoring
	function automatic logic [ANGLE_W-1:0] orientation_angle(input longint vx, input longint vy);
		longint          x;
		longint          y;
		longint          z;
		longint          base;
		longint          dx;
		longint          dy;
		longint          theta;
		longint          h;
		longint unsigned mag;
		int              shift;
		x = vy;
		y = vx;
		z = 0;
		base = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			base = HALF_TURN;
		end
		mag = (y < 0) ? -y : y;
		if (x > mag) begin
			mag = x;
		end
		shift = 0;
		while (mag < (64'd1 << NORM_MSB)) begin
			mag = mag << 1;
			shift++;
		end
		x = x <<< shift;
		y = y <<< shift;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + rotation_arc(i);
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - rotation_arc(i);
			end
		end
		theta = base + z;
		if (theta < 0) begin
			theta = theta + FULL_TURN;
		end
		h = (theta + ROUND_BIAS) >>> ROUND_SHIFT;
		if (h >= HALF_RANGE) begin
			h = h - HALF_RANGE;
		end
		return ANGLE_W'(ANGLE_OFFSET + h);
	endfunction

	// Input-side prediction, output-side checking and the watchdog.
	always @(posedge clk) begin
		longint  gx;
		longint  gy;
		longint  vx;
		longint  vy;
		orient_t want;
		if (arst_n) begin
			if (pix.valid && pix.ready) begin
				gx = pix.grad_x;
				gy = pix.grad_y;
				sum_vx = sum_vx + ACC_W'(2 * gx * gy);
				sum_vy = sum_vy + ACC_W'(gx * gx - gy * gy);
				if (pix.last_in_block) begin
					vx = $signed(sum_vx);
					vy = $signed(sum_vy);
					if (vx == 0) begin
						want.angle = '0;
						want.flat_block = 1'b1;
					end else begin
						want.angle = orientation_angle(vx, vy);
						want.flat_block = 1'b0;
					end
					expected_orient.insert(expected_orient.size(), want);
					sum_vx = '0;
					sum_vy = '0;
				end
			end
			if (res.valid && res.ready) begin
				if (expected_orient.size() == 0) begin
					$error("unexpected result transaction: angle=%0d flat_block=%0d",
						res.angle, res.flat_block);
					mismatches++;
				end else begin
					want = expected_orient.pop_front();
					if (res.angle !== want.angle) begin
						$error("angle: expected %0d, actual %0d", want.angle, res.angle);
						mismatches++;
					end
					if (res.flat_block !== want.flat_block) begin
						$error("flat_block: expected %0d, actual %0d",
							want.flat_block, res.flat_block);
						mismatches++;
					end
				end
			end
			if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Result receiver; a requested hold-off overrides random idling.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				res.ready = 1'b0;
				hold_off_cycles--;
			end else begin
				res.ready = ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Entered at a falling edge; returns at the falling edge after acceptance.
	task automatic send_pixel(input int gx, input int gy, input bit last);
		while ($urandom_range(99) < src_idle_pct) begin
			pix.valid = 1'b0;
			@(negedge clk);
		end
		pix.valid = 1'b1;
		pix.grad_x = GRAD_W'(gx);
		pix.grad_y = GRAD_W'(gy);
		pix.last_in_block = last;
		do begin
			@(posedge clk);
		end while (!pix.ready);
		@(negedge clk);
	endtask

	function automatic int random_grad();
		int r;
		r = $urandom_range(99);
		if (r < 10) begin
			case ($urandom_range(4))
				0:       return GRAD_MIN;
				1:       return GRAD_MAX;
				2:       return -1;
				3:       return 1;
				default: return 0;
			endcase
		end else if (r < 35) begin
			return int'($urandom_range(128)) - 64;
		end
		return int'($urandom_range(2 ** GRAD_W - 1)) + GRAD_MIN;
	endfunction

	function automatic int block_length();
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			return $urandom_range(1, 8);
		end else if (r < 95) begin
			return $urandom_range(9, 64);
		end
		return $urandom_range(65, 300);
	endfunction

	task automatic run_directed_extremes();
		src_idle_pct = 17;
		snk_idle_pct = 48;
		send_pixel(GRAD_MAX, GRAD_MAX, 1'b1);
		send_pixel(GRAD_MIN, GRAD_MIN, 1'b1);
		send_pixel(GRAD_MIN, GRAD_MAX, 1'b1);
		send_pixel(GRAD_MAX, GRAD_MIN, 1'b1);
		// vx zero: pure horizontal, pure vertical, all zero
		send_pixel(0, GRAD_MAX, 1'b1);
		send_pixel(GRAD_MIN, 0, 1'b1);
		send_pixel(0, 0, 1'b1);
		// vy negative takes the 180 degree base; vy zero does not
		send_pixel(1, GRAD_MIN, 1'b1);
		send_pixel(-1, 1, 1'b1);
		send_pixel(1, 1, 1'b1);
		// vx cancels across the block while vy stays nonzero
		send_pixel(2, 1, 1'b0);
		send_pixel(2, -1, 1'b1);
		// multi-pixel block, flag only on the last
		send_pixel(100, -3, 1'b0);
		send_pixel(-5, 7, 1'b0);
		send_pixel(0, 0, 1'b0);
		send_pixel(GRAD_MAX, GRAD_MIN, 1'b1);
		send_pixel(3, 4, 1'b1);
		send_pixel(-4, 3, 1'b1);
	endtask

	// Receiver holds off while single-pixel blocks keep coming.
	task automatic run_backpressure_fill();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_off_cycles = 400;
		repeat (60) begin
			send_pixel(random_grad(), random_grad(), 1'b1);
		end
	endtask

	task automatic run_random_blocks(input int src_pct, input int snk_pct, input int count);
		int sent;
		int len;
		int kind;
		int a;
		int b;
		bit vertical;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(99);
			len = block_length();
			if (kind < 8) begin
				vertical = $urandom_range(1);
				for (int k = 0; k < len; k++) begin
					if (vertical) begin
						send_pixel(0, random_grad(), k == len - 1);
					end else begin
						send_pixel(random_grad(), 0, k == len - 1);
					end
				end
				sent += len;
			end else if (kind < 14) begin
				a = random_grad();
				b = int'($urandom_range(2 * GRAD_MAX)) - GRAD_MAX;
				send_pixel(a, b, 1'b0);
				send_pixel(a, -b, 1'b1);
				sent += 2;
			end else begin
				for (int k = 0; k < len; k++) begin
					send_pixel(random_grad(), random_grad(), k == len - 1);
				end
				sent += len;
			end
		end
	endtask

	// long block of extreme pixels: large vx sum, vy stays zero
	task automatic run_long_block();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		repeat (LONG_PIXELS) begin
			send_pixel(GRAD_MIN, GRAD_MIN, 1'b0);
		end
		send_pixel(GRAD_MIN, GRAD_MIN, 1'b1);
		send_pixel(5, -7, 1'b1);
	endtask

	initial begin
		pix.valid = 1'b0;
		pix.grad_x = '0;
		pix.grad_y = '0;
		pix.last_in_block = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		run_directed_extremes();
		run_backpressure_fill();
		run_random_blocks(17, 48, 210);
		run_random_blocks(48, 17, 210);
		run_random_blocks(0, 0, 210);
		run_long_block();
		pix.valid = 1'b0;
		while (expected_orient.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/bgo_pkg.sv
sv/bgo_if.sv
sv/bgo_front.sv
sv/bgo_queue.sv
sv/bgo_cordic.sv
sv/block_gradient_orientation.sv
tb/sv/testbench.sv
